FILE: rtl/co2_baseline_recalibration_fsm_unit_assert.svh
// ----------------------------------------------------------------------------
// co2 baseline recalibration assertion macros
// shared concurrent assertion forms for the port monitor
// ----------------------------------------------------------------------------
`ifndef CO2_BASELINE_RECALIBRATION_FSM_UNIT_ASSERT_SVH
`define CO2_BASELINE_RECALIBRATION_FSM_UNIT_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define CBR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is low
`define CBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg
// types, codes and helpers of the co2 baseline recalibration unit
// ----------------------------------------------------------------------------
package cbr_pkg;

  localparam int unsigned NumRegs = 7;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_BASELINE   = 3'd0,
    REG_FIRST_OFS  = 3'd1,
    REG_INIT_OFS   = 3'd2,
    REG_STD_OFS    = 3'd3,
    REG_FIRST_PER  = 3'd4,
    REG_INIT_PER   = 3'd5,
    REG_STD_PER    = 3'd6
  } cbr_reg_e;

  typedef enum logic {
    OP_READING = 1'b0,
    OP_RESET   = 1'b1
  } cbr_op_e;

  typedef enum logic [1:0] {
    STAGE_FIRST = 2'd0,
    STAGE_INIT  = 2'd1,
    STAGE_STD   = 2'd2
  } cbr_stage_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_READ_FAIL = 2'd1,
    STATUS_CAL_FAIL  = 2'd2
  } cbr_status_e;

  typedef enum logic [1:0] {
    CAL_NONE   = 2'd0,
    CAL_BELOW  = 2'd1,
    CAL_PERIOD = 2'd2
  } cbr_cal_e;

  localparam logic [15:0] PpmMax      = 16'hFFFF;
  localparam logic [15:0] ReplyFail   = 16'hFFFF;
  localparam logic [15:0] ReplyBias   = 16'h8000;
  localparam logic [7:0]  FailSat     = 8'hFF;

  localparam logic [15:0] RstBaseline = 16'd400;
  localparam logic [15:0] RstFirstOfs = 16'd1000;
  localparam logic [15:0] RstInitOfs  = 16'd300;
  localparam logic [15:0] RstStdOfs   = 16'd100;
  localparam logic [15:0] RstFirstPer = 16'd12;
  localparam logic [15:0] RstInitPer  = 16'd96;
  localparam logic [15:0] RstStdPer   = 16'd1008;

  typedef struct packed {
    logic [15:0] baseline;
    logic [15:0] first_ofs;
    logic [15:0] init_ofs;
    logic [15:0] std_ofs;
    logic [15:0] first_per;
    logic [15:0] init_per;
    logic [15:0] std_per;
  } cbr_cfg_t;

  typedef struct packed {
    cbr_op_e     operation;
    logic        read_ok;
    logic [15:0] co2_ppm;
    logic [15:0] cal_reply;
  } cbr_item_t;

  typedef struct packed {
    cbr_stage_e  stage;
    logic [15:0] period_count;
    logic [15:0] period_min;
    logic        excursion;
    logic [7:0]  fail_count;
    logic [15:0] correction;
    logic [31:0] age_count;
    logic [31:0] cal_count;
  } cbr_state_t;

  typedef struct packed {
    cbr_status_e status;
    cbr_cal_e    cal_kind;
    logic [15:0] cal_target;
    cbr_stage_e  stage;
    logic [15:0] readings_left;
    logic        pretrigger_warn;
    logic [15:0] last_correction;
    logic [31:0] correction_age;
    logic [31:0] cal_total;
    logic [7:0]  fail_streak;
  } cbr_res_t;

  function automatic logic [15:0] stage_offset(cbr_cfg_t cfg, cbr_stage_e stg);
    logic [15:0] ofs;
    unique case (stg)
      STAGE_FIRST: ofs = cfg.first_ofs;
      STAGE_INIT:  ofs = cfg.init_ofs;
      default:     ofs = cfg.std_ofs;
    endcase
    return ofs;
  endfunction

  function automatic logic [15:0] stage_period(cbr_cfg_t cfg, cbr_stage_e stg);
    logic [15:0] per;
    unique case (stg)
      STAGE_FIRST: per = cfg.first_per;
      STAGE_INIT:  per = cfg.init_per;
      default:     per = cfg.std_per;
    endcase
    return per;
  endfunction

endpackage

FILE: rtl/co2_baseline_recalibration_fsm_unit.sv
// ----------------------------------------------------------------------------
// co2_baseline_recalibration_fsm_unit
// co2 baseline recalibration controller with stream in and out
// ----------------------------------------------------------------------------
// Each input word is a co2 reading (or a reset command for the calibration
// machine) and produces exactly one result word. The unit takes one word per
// clock cycle while the result stream is not stalled; a word waits in the
// input register and moves into the result register, which drives the output,
// when that register is free or draining.
// All per-reading work (minimum tracking, below-baseline check, period count,
// stage advance and clamped target) is one pass of compare/add logic between
// those two registers, and the calibration state is updated in the same cycle
// that the result is loaded, so back-to-back words see each other's effects.
// Configuration registers are write-only; writes to unused indexes are dropped.
// The user writes them while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module co2_baseline_recalibration_fsm_unit
  import cbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // co2_ppm[15:0], cal_reply[31:16]
  input  logic [1:0]         s_axis_tuser,  // operation[0], read_ok[1]
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // status[1:0], cal_kind[3:2], cal_target[19:4], stage[21:20],
  // readings_left[37:22], pretrigger_warn[38], last_correction[54:39],
  // correction_age[86:55], cal_total[118:87], fail_streak[126:119], zero[127]
  output logic [127:0]       m_axis_tdata
);

  cbr_cfg_t   cfg;
  cbr_state_t state_q, state_d;
  cbr_item_t  in_q;
  logic       in_valid_q;
  cbr_res_t   res_d, out_q;
  logic       out_valid_q;
  logic       advance;
  logic       in_take;

  cbr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cbr_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (in_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // a held word moves on whenever the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.operation <= cbr_op_e'(s_axis_tuser[0]);
      in_q.read_ok   <= s_axis_tuser[1];
      in_q.co2_ppm   <= s_axis_tdata[15:0];
      in_q.cal_reply <= s_axis_tdata[31:16];
    end
  end

  // calibration state, committed as the word passes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage        <= STAGE_FIRST;
      state_q.period_count <= RstFirstPer;
      state_q.period_min   <= PpmMax;
      state_q.excursion    <= 1'b0;
      state_q.fail_count   <= '0;
      state_q.correction   <= '0;
      state_q.age_count    <= '0;
      state_q.cal_count    <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_q.fail_streak,
                          out_q.cal_total,
                          out_q.correction_age,
                          out_q.last_correction,
                          out_q.pretrigger_warn,
                          out_q.readings_left,
                          out_q.stage,
                          out_q.cal_target,
                          out_q.cal_kind,
                          out_q.status};

endmodule

FILE: rtl/cbr_cfg_regs.sv
// ----------------------------------------------------------------------------
// cbr_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module cbr_cfg_regs
  import cbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output cbr_cfg_t           cfg_o
);

  cbr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cbr_reg_e'(cfg_idx_i))
        REG_BASELINE:  cfg_d.baseline  = cfg_wdata_i;
        REG_FIRST_OFS: cfg_d.first_ofs = cfg_wdata_i;
        REG_INIT_OFS:  cfg_d.init_ofs  = cfg_wdata_i;
        REG_STD_OFS:   cfg_d.std_ofs   = cfg_wdata_i;
        REG_FIRST_PER: cfg_d.first_per = cfg_wdata_i;
        REG_INIT_PER:  cfg_d.init_per  = cfg_wdata_i;
        REG_STD_PER:   cfg_d.std_per   = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline  <= RstBaseline;
      cfg_q.first_ofs <= RstFirstOfs;
      cfg_q.init_ofs  <= RstInitOfs;
      cfg_q.std_ofs   <= RstStdOfs;
      cfg_q.first_per <= RstFirstPer;
      cfg_q.init_per  <= RstInitPer;
      cfg_q.std_per   <= RstStdPer;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/cbr_step.sv
// ----------------------------------------------------------------------------
// cbr_step
// next-state and result logic for one reading or reset command
// ----------------------------------------------------------------------------
module cbr_step
  import cbr_pkg::*;
(
  input  cbr_cfg_t   cfg_i,
  input  cbr_state_t state_i,
  input  cbr_item_t  item_i,
  output cbr_state_t state_o,
  output cbr_res_t   res_o
);

  always_comb begin
    cbr_state_t  nxt;
    cbr_status_e status;
    cbr_cal_e    kind;
    logic [15:0] target;
    logic [15:0] min_new;
    logic [15:0] ofs;
    logic [15:0] gap;
    logic        early_fail;
    cbr_stage_e  stage_nxt;

    nxt        = state_i;
    status     = STATUS_OK;
    kind       = CAL_NONE;
    target     = '0;
    min_new    = state_i.period_min;
    ofs        = '0;
    gap        = '0;
    early_fail = 1'b0;
    stage_nxt  = state_i.stage;

    if (item_i.operation == OP_RESET) begin
      nxt.stage        = STAGE_FIRST;
      nxt.excursion    = 1'b0;
      nxt.period_min   = PpmMax;
      nxt.period_count = cfg_i.first_per;
      nxt.fail_count   = '0;
    end else if (!item_i.read_ok || item_i.co2_ppm == '0) begin
      if (state_i.fail_count != FailSat) begin
        nxt.fail_count = state_i.fail_count + 8'd1;
      end
      status = STATUS_READ_FAIL;
    end else begin
      nxt.fail_count = '0;
      if (item_i.co2_ppm < state_i.period_min) begin
        min_new = item_i.co2_ppm;
      end
      nxt.period_min = min_new;
      nxt.age_count  = state_i.age_count + 32'd1;

      // first dip below baseline in this period
      if (item_i.co2_ppm < cfg_i.baseline && !state_i.excursion) begin
        nxt.excursion = 1'b1;
        gap    = cfg_i.baseline - item_i.co2_ppm;
        ofs    = stage_offset(cfg_i, state_i.stage);
        target = (gap > ofs) ? item_i.co2_ppm + ofs : cfg_i.baseline;
        kind   = CAL_BELOW;
        nxt.cal_count  = state_i.cal_count + 32'd1;
        nxt.correction = item_i.cal_reply - ReplyBias;
        if (item_i.cal_reply == ReplyFail) begin
          status     = STATUS_CAL_FAIL;
          early_fail = 1'b1;
        end
      end

      if (!early_fail) begin
        if (state_i.period_count <= 16'd1) begin
          case (state_i.stage)
            STAGE_FIRST: stage_nxt = STAGE_INIT;
            default:     stage_nxt = STAGE_STD;
          endcase
          nxt.stage        = stage_nxt;
          nxt.period_count = stage_period(cfg_i, stage_nxt);
          nxt.period_min   = PpmMax;
          if (nxt.excursion) begin
            nxt.excursion = 1'b0;
          end else begin
            // pull the period minimum toward baseline, clamped
            ofs = stage_offset(cfg_i, stage_nxt);
            gap = min_new - cfg_i.baseline;
            if (min_new < cfg_i.baseline || gap > ofs) begin
              gap = ofs;
            end
            target         = item_i.co2_ppm - gap;
            kind           = CAL_PERIOD;
            nxt.age_count  = '0;
            nxt.cal_count  = state_i.cal_count + 32'd1;
            nxt.correction = item_i.cal_reply - ReplyBias;
            if (item_i.cal_reply == ReplyFail) begin
              status = STATUS_CAL_FAIL;
            end
          end
        end else begin
          nxt.period_count = state_i.period_count - 16'd1;
        end
      end
    end

    state_o               = nxt;
    res_o.status          = status;
    res_o.cal_kind        = kind;
    res_o.cal_target      = target;
    res_o.stage           = nxt.stage;
    res_o.readings_left   = nxt.period_count;
    res_o.pretrigger_warn = (nxt.period_count <= 16'd1);
    res_o.last_correction = nxt.correction;
    res_o.correction_age  = nxt.age_count;
    res_o.cal_total       = nxt.cal_count;
    res_o.fail_streak     = nxt.fail_count;
  end

endmodule

FILE: rtl/cbr_sva.sv
// ----------------------------------------------------------------------------
// cbr_sva
// port-level assertions for the co2 baseline recalibration unit
// ----------------------------------------------------------------------------
`include "co2_baseline_recalibration_fsm_unit_assert.svh"

module cbr_sva
  import cbr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [127:0]       m_axis_tdata
);

  // stalled result holds
  `CBR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // no command means no target
  `CBR_ASSERT_NOW(a_no_cal_no_target, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[3:2] == 2'd0, m_axis_tdata[19:4] == 16'd0, "target without a recalibration")

  // warning flag tracks the period counter
  `CBR_ASSERT_NOW(a_warn_match, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[38] == (m_axis_tdata[37:22] <= 16'd1), "pretrigger warning out of step")

  // a read failure never commands a recalibration
  `CBR_ASSERT_NOW(a_fail_no_cal, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1:0] == 2'd1, m_axis_tdata[3:2] == 2'd0 && m_axis_tdata[126:119] != 8'd0, "read failure with recalibration")

  // an empty result register never blocks the input
  `CBR_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

bind co2_baseline_recalibration_fsm_unit cbr_sva u_cbr_sva (.*);
